[rtl/mpfd_pkg.sv]
// Shared types and codes for the page framebuffer drawing block.
package mpfd_pkg;

    localparam logic [1:0] MODE_FILL   = 2'd0;
    localparam logic [1:0] MODE_WINDOW = 2'd1;
    localparam logic [1:0] MODE_BITMAP = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    // Byte operations; the first three match the color_op codes.
    localparam logic [1:0] OP_CLR  = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_INV  = 2'd2;
    localparam logic [1:0] OP_KEEP = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_CLIP  = 2'd1;
    localparam logic [1:0] STAT_NOWIN = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam int CALC = 10;

    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic [7:0] mask;
    } t_rmw_req;

endpackage

[rtl/mpfd_ram.sv]
// Generic simple dual-port RAM with registered read.
module mpfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mpfd_rmw.sv]
// Frame store with read-modify-write of one byte per cycle and clearing pass.
module mpfd_rmw #(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mpfd_pkg::t_rmw_req       i_req,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    output logic [7:0]               o_rdata,
    output logic                     o_clearing
);

    localparam int AW = $clog2(DEPTH);

    mpfd_pkg::t_rmw_req r_req;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      r_clr_addr;
    logic               r_clearing;
    logic [7:0]         w_q;
    logic [7:0]         w_mod;
    logic               w_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.valid <= 1'b0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            r_req.valid <= i_req.valid;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
        r_req.op   <= i_req.op;
        r_req.mask <= i_req.mask;
        r_addr     <= i_addr;
    end

    always_comb begin
        case (r_req.op)
            mpfd_pkg::OP_CLR: w_mod = w_q & ~r_req.mask;
            mpfd_pkg::OP_SET: w_mod = w_q | r_req.mask;
            mpfd_pkg::OP_INV: w_mod = w_q ^ r_req.mask;
            default:          w_mod = w_q;
        endcase
    end

    assign w_we = r_clearing || (r_req.valid && r_req.op != mpfd_pkg::OP_KEEP);

    mpfd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_clearing ? r_clr_addr : r_addr),
        .i_wdata (r_clearing ? 8'h00 : w_mod),
        .i_raddr (i_addr),
        .o_rdata (w_q)
    );

    assign o_rdata    = w_q;
    assign o_clearing = r_clearing;

endmodule

[rtl/mono_page_framebuffer_draw.sv]
// Top level: page framebuffer with rectangle fill, bitmap window and refresh read.
// After reset the block clears the frame store and accepts no item meanwhile;
// configuration writes are taken at any time. Afterwards one item is worked at a
// time and its result is registered once the work ends. A bitmap byte touches each
// on-panel column it covers, and a rectangle fill each frame byte it covers (pages
// times clipped columns). The rate is set by the single read-modify-write port of
// the frame store, one byte per cycle.
// A new item is taken once the previous result has been collected.
module mono_page_framebuffer_draw #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_mode,
    input  logic [6:0] i_pos_x,
    input  logic [5:0] i_pos_y,
    input  logic [7:0] i_rect_width,
    input  logic [6:0] i_rect_height,
    input  logic [1:0] i_color_op,
    input  logic [7:0] i_bitmap_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data,
    output logic [1:0] o_status,
    output logic       o_window_done
);

    localparam int C     = mpfd_pkg::CALC;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT / 8;
    localparam int AW    = $clog2(DEPTH);
    localparam int PG    = MAX_HEIGHT / 8;
    localparam int PGW   = (PG > 1) ? $clog2(PG) : 1;
    localparam int CW    = $clog2(MAX_WIDTH);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    logic [2:0] r_state, n_state;

    logic [7:0] r_pw;
    logic [6:0] r_ph;

    logic [6:0] r_win_left;
    logic [7:0] r_win_width;
    logic [7:0] r_win_bottom;
    logic [6:0] r_cur_row;
    logic [7:0] r_cur_col;
    logic       r_win_open;

    logic [1:0] r_mode, r_op;
    logic [6:0] r_x;
    logic [5:0] r_y;
    logic [7:0] r_rw, r_bits;
    logic [6:0] r_rh;

    logic [CW-1:0]  r_col, r_col_first, r_col_last;
    logic [PGW-1:0] r_page, r_page_first, r_page_last;
    logic [2:0]     r_lo, r_hi;
    logic [AW-1:0]  r_base;

    logic       r_ovalid, r_done;
    logic [7:0] r_rdata;
    logic [1:0] r_status;

    // effective panel
    logic [C-1:0] w_ew, w_eh, w_h1;
    // fill
    logic [C-1:0] f_cend, f_rend, f_ce, f_re, f_re_m1;
    logic         f_empty, f_clip, f_any;
    // bitmap
    logic [C-1:0] b_diff, b_n, b_c0, b_cend, b_ce, b_next;
    logic         b_row_out, b_clip, b_any, b_wrap, b_close;
    logic [6:0]   b_row_n;
    // read
    logic         d_out;
    // setup selection
    logic [C-1:0]   s_pg, s_col0, s_col1, s_pglast;
    logic [2:0]     s_lo, s_hi;
    logic           s_work;
    logic [1:0]     s_status;
    logic [2*C-1:0] w_mul;

    logic [2:0]         w_lo_eff, w_hi_eff, w_k;
    mpfd_pkg::t_rmw_req w_req;
    logic [AW-1:0]      w_addr;
    logic [7:0]         w_rdata;
    logic               w_clearing;
    logic               w_last_col, w_last_page;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE) && !r_ovalid;

    assign w_ew = ({2'b0, r_pw} < C'(MAX_WIDTH)) ? {2'b0, r_pw} : C'(MAX_WIDTH);
    assign w_h1 = ({3'b0, r_ph} < C'(MAX_HEIGHT)) ? {3'b0, r_ph} : C'(MAX_HEIGHT);
    assign w_eh = w_h1 & ~C'(7);

    assign f_cend  = {3'b0, r_x} + {2'b0, r_rw};
    assign f_rend  = {4'b0, r_y} + {3'b0, r_rh};
    assign f_empty = (r_rw == 8'd0) || (r_rh == 7'd0);
    assign f_clip  = !f_empty && ((f_cend > w_ew) || (f_rend > w_eh));
    assign f_ce    = (f_cend < w_ew) ? f_cend : w_ew;
    assign f_re    = (f_rend < w_eh) ? f_rend : w_eh;
    assign f_any   = !f_empty && ({3'b0, r_x} < f_ce) && ({4'b0, r_y} < f_re);
    assign f_re_m1 = f_re - 1'b1;

    assign b_diff    = {2'b0, r_win_width} - {2'b0, r_cur_col};
    assign b_n       = (b_diff >= C'(8)) ? C'(8) : b_diff;
    assign b_c0      = {3'b0, r_win_left} + {2'b0, r_cur_col};
    assign b_cend    = b_c0 + b_n;
    assign b_row_out = {3'b0, r_cur_row} >= w_eh;
    assign b_clip    = b_row_out || (b_cend > w_ew);
    assign b_ce      = (b_cend < w_ew) ? b_cend : w_ew;
    assign b_any     = !b_row_out && (b_c0 < b_ce);
    assign b_next    = {2'b0, r_cur_col} + C'(8);
    assign b_wrap    = b_next >= {2'b0, r_win_width};
    assign b_row_n   = r_cur_row + 1'b1;
    assign b_close   = b_wrap && ({1'b0, b_row_n} >= r_win_bottom);

    assign d_out = ({3'b0, r_x} >= w_ew) || ({4'b0, r_y} >= (w_eh >> 3));

    always_comb begin
        s_pg     = '0;
        s_col0   = '0;
        s_col1   = '0;
        s_pglast = '0;
        s_lo     = 3'd0;
        s_hi     = 3'd7;
        s_work   = 1'b0;
        s_status = mpfd_pkg::STAT_OK;
        case (r_mode)
            mpfd_pkg::MODE_FILL: begin
                s_pg     = {4'b0, r_y} >> 3;
                s_col0   = {3'b0, r_x};
                s_col1   = f_ce - 1'b1;
                s_pglast = f_re_m1 >> 3;
                s_lo     = r_y[2:0];
                s_hi     = f_re_m1[2:0];
                s_work   = f_any;
                s_status = f_clip ? mpfd_pkg::STAT_CLIP : mpfd_pkg::STAT_OK;
            end
            mpfd_pkg::MODE_BITMAP: begin
                s_pg     = {3'b0, r_cur_row} >> 3;
                s_col0   = b_c0;
                s_col1   = b_ce - 1'b1;
                s_pglast = {3'b0, r_cur_row} >> 3;
                s_lo     = r_cur_row[2:0];
                s_hi     = r_cur_row[2:0];
                s_work   = r_win_open && b_any;
                if (!r_win_open) begin
                    s_status = mpfd_pkg::STAT_NOWIN;
                end else if (b_clip) begin
                    s_status = mpfd_pkg::STAT_CLIP;
                end
            end
            mpfd_pkg::MODE_READ: begin
                s_pg     = {4'b0, r_y};
                s_col0   = {3'b0, r_x};
                s_col1   = {3'b0, r_x};
                s_pglast = {4'b0, r_y};
                s_work   = !d_out;
                s_status = d_out ? mpfd_pkg::STAT_CLIP : mpfd_pkg::STAT_OK;
            end
            default: begin
                s_work = 1'b0;
            end
        endcase
    end

    assign w_mul = (2*C)'(s_pg) * (2*C)'(w_ew);

    // per-byte request during the sweep
    assign w_lo_eff    = (r_page == r_page_first) ? r_lo : 3'd0;
    assign w_hi_eff    = (r_page == r_page_last) ? r_hi : 3'd7;
    assign w_k         = 3'(r_col - r_col_first);
    assign w_last_col  = (r_col == r_col_last);
    assign w_last_page = (r_page == r_page_last);
    assign w_addr      = r_base + AW'(r_col);

    always_comb begin
        w_req.valid = (r_state == S_RUN);
        w_req.mask  = (8'hFF << w_lo_eff) & (8'hFF >> (3'd7 - w_hi_eff));
        case (r_mode)
            mpfd_pkg::MODE_FILL:   w_req.op = r_op;
            mpfd_pkg::MODE_BITMAP: w_req.op = r_bits[3'd7 - w_k] ? mpfd_pkg::OP_SET
                                                                 : mpfd_pkg::OP_CLR;
            default:               w_req.op = mpfd_pkg::OP_KEEP;
        endcase
    end

    mpfd_rmw #(.DEPTH(DEPTH)) u_rmw (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_addr     (w_addr),
        .o_rdata    (w_rdata),
        .o_clearing (w_clearing)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:   if (!w_clearing) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid && o_in_ready) n_state = S_SETUP;
            S_SETUP: n_state = s_work ? S_RUN : S_IDLE;
            S_RUN:   if (w_last_col && w_last_page) n_state = S_DRAIN;
            S_DRAIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_pw         <= 8'd128;
            r_ph         <= 7'd64;
            r_win_left   <= '0;
            r_win_width  <= '0;
            r_win_bottom <= '0;
            r_cur_row    <= '0;
            r_cur_col    <= '0;
            r_win_open   <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == mpfd_pkg::CFG_WIDTH) begin
                    r_pw <= i_cfg_data;
                end else begin
                    r_ph <= i_cfg_data[6:0];
                end
            end
            if (o_out_valid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_SETUP) begin
                if (!s_work) begin
                    r_ovalid <= 1'b1;
                end
                if (r_mode == mpfd_pkg::MODE_WINDOW) begin
                    r_win_left   <= r_x;
                    r_win_width  <= r_rw;
                    r_win_bottom <= {2'b0, r_y} + {1'b0, r_rh};
                    r_cur_row    <= {1'b0, r_y};
                    r_cur_col    <= '0;
                    r_win_open   <= (r_rw != 8'd0) && (r_rh != 7'd0);
                end else if (r_mode == mpfd_pkg::MODE_BITMAP && r_win_open) begin
                    if (b_wrap) begin
                        r_cur_col <= '0;
                        r_cur_row <= b_row_n;
                        if (b_close) begin
                            r_win_open <= 1'b0;
                        end
                    end else begin
                        r_cur_col <= b_next[7:0];
                    end
                end
            end
            if (r_state == S_DRAIN) begin
                r_ovalid <= 1'b1;
            end
        end
    end

    // item and sweep registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_mode <= i_mode;
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_rw   <= i_rect_width;
            r_rh   <= i_rect_height;
            r_op   <= i_color_op;
            r_bits <= i_bitmap_byte;
        end
        if (r_state == S_SETUP) begin
            r_col        <= CW'(s_col0);
            r_col_first  <= CW'(s_col0);
            r_col_last   <= CW'(s_col1);
            r_page       <= PGW'(s_pg);
            r_page_first <= PGW'(s_pg);
            r_page_last  <= PGW'(s_pglast);
            r_lo         <= s_lo;
            r_hi         <= s_hi;
            r_base       <= AW'(w_mul);
            r_status     <= s_status;
            r_rdata      <= 8'h00;
            r_done       <= (r_mode == mpfd_pkg::MODE_BITMAP) && r_win_open && b_close;
        end
        if (r_state == S_RUN) begin
            if (w_last_col) begin
                // advance to the next page
                r_col  <= r_col_first;
                r_page <= r_page + 1'b1;
                r_base <= r_base + AW'(w_ew);
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
        if (r_state == S_DRAIN && r_mode == mpfd_pkg::MODE_READ) begin
            r_rdata <= w_rdata;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_read_data   = r_rdata;
    assign o_status      = r_status;
    assign o_window_done = r_done;

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_in_ready)
        else $error("item accepted during clearing pass");

    a_addr_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> ({1'b0, w_addr} < (AW+1)'(DEPTH)))
        else $error("frame address beyond store");

    a_done_only_bitmap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_done) |-> (r_mode == mpfd_pkg::MODE_BITMAP))
        else $error("window_done outside bitmap mode");

    a_read_only_mode3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_mode != mpfd_pkg::MODE_READ) |-> (r_rdata == 8'h00))
        else $error("read data outside read mode");

endmodule
